[src/assert_macros.svh]
// Assertion macros used by the RTL file of the validator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define CHK_IMPLY(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define CHK_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

[src/hlv_pkg.sv]
// Types and constants of the host name label validator.
package hlv_pkg;

  localparam int CodeW    = 16;
  localparam int CharW    = 7;
  localparam int LabelW   = 7;
  localparam int KeptW    = 9;
  localparam int MaxLblW  = 6;
  localparam int MaxNameW = 8;
  localparam int CfgDataW = 8;
  localparam int CfgIdxW  = 1;
  localparam int OutDataW = 24;

  localparam logic [LabelW-1:0]   LabelSat     = 7'd127;
  localparam logic [KeptW-1:0]    KeptSat      = 9'd511;
  localparam logic [CharW-1:0]    CaseShift    = 7'd32;
  localparam logic [MaxLblW-1:0]  MaxLblReset  = 6'd63;
  localparam logic [MaxNameW-1:0] MaxNameReset = 8'd255;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMaxLabel = 1'b0;
  localparam logic [CfgIdxW-1:0] RegMaxName  = 1'b1;

  // Result kinds
  localparam logic KindChar    = 1'b0;
  localparam logic KindVerdict = 1'b1;

  // ASCII codes with a role of their own
  localparam logic [CodeW-1:0] ChPeriod = 16'h002E;
  localparam logic [CodeW-1:0] ChHyphen = 16'h002D;

  typedef struct packed {
    logic              kind;
    logic [CharW-1:0]  out_char;
    logic              host_valid;
    logic [KeptW-1:0]  name_length;
  } result_t;

endpackage

[src/hostname_label_validator.sv]
// Top level of the host name label validator.
//
// Input stream: one UTF-16 code unit per word on in_tdata; in_tlast marks
// the end of the text and asks for the verdict (its code is ignored).
// Leading units that are not letters or digits are skipped; letters,
// digits, periods and hyphens are then copied out, upper case folded to
// lower case, other units dropped; the first whitespace ends the copying.
// Output stream: out_tuser = 0 carries a kept character, out_tuser = 1 the
// verdict (valid flag and kept count, saturating at 511), after which the
// block starts on a new name.
// Flow: one word is accepted each cycle while in_tready is high; a result
// is registered in the output or the skid register. The per-word state
// update is a few compares and two small saturating counters.
// Stall: a two-entry output buffer (output register plus skid register)
// keeps in_tready high while one result waits; in_tready drops only when
// both entries are full. Words that make no result pass with no slot used.
// Reset (synchronous, rst_n low) empties the buffer, clears the scan state
// and loads the limits with 63 and 255. Limits are written through cfg_we /
// cfg_index / cfg_wdata, by users only while the block is idle; unchecked.
`include "assert_macros.svh"

module hostname_label_validator (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata fields, low bit up: code[15:0]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [hlv_pkg::CodeW-1:0]         in_tdata,
  input  logic                              in_tlast,
  // out_tdata fields, low bit up: out_char[6:0], host_valid[7],
  // name_length[16:8], zero fill[23:17]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [hlv_pkg::OutDataW-1:0]      out_tdata,
  // out_tuser fields, low bit up: kind[0]
  output logic                              out_tuser,
  input  logic                              cfg_we,
  input  logic [hlv_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [hlv_pkg::CfgDataW-1:0]      cfg_wdata
);

  typedef enum logic [1:0] {
    PH_SKIP = 2'd0,
    PH_COPY = 2'd1,
    PH_STOP = 2'd2
  } phase_t;

  phase_t                          phase_r, phase_nxt;
  logic [hlv_pkg::LabelW-1:0]      label_cnt_r, label_cnt_nxt;
  logic [hlv_pkg::KeptW-1:0]       kept_cnt_r, kept_cnt_nxt;
  logic                            hyph_r, hyph_nxt;
  logic                            vsf_r, vsf_nxt;
  logic [hlv_pkg::MaxLblW-1:0]     max_lbl_r;
  logic [hlv_pkg::MaxNameW-1:0]    max_name_r;

  logic                            out_valid_r, skid_valid_r;
  hlv_pkg::result_t                out_r, skid_r;

  logic                            in_acc;
  logic                            res_vld;
  hlv_pkg::result_t                res;

  logic [hlv_pkg::CodeW-1:0]       c;
  logic                            c_lower, c_upper, c_digit, c_space, c_alnum;
  logic [hlv_pkg::LabelW-1:0]      label_inc;
  logic                            label_over;
  logic [hlv_pkg::KeptW-1:0]       kept_inc;
  logic                            copy_now;
  logic                            verdict_ok;

  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  // Character classes
  assign c       = in_tdata;
  assign c_lower = (c >= 16'h0061) && (c <= 16'h007A);
  assign c_upper = (c >= 16'h0041) && (c <= 16'h005A);
  assign c_digit = (c >= 16'h0030) && (c <= 16'h0039);
  assign c_alnum = c_lower || c_upper || c_digit;
  assign c_space = c inside {[16'h0009:16'h000D], 16'h0020, 16'h0085, 16'h00A0,
                             16'h1680, [16'h2000:16'h200A], 16'h2028, 16'h2029,
                             16'h202F, 16'h205F, 16'h3000};

  // Saturating counters and limit checks
  assign label_inc  = (label_cnt_r < hlv_pkg::LabelSat) ? label_cnt_r + 7'd1 : label_cnt_r;
  assign label_over = label_inc > {1'b0, max_lbl_r};
  assign kept_inc   = (kept_cnt_r < hlv_pkg::KeptSat) ? kept_cnt_r + 9'd1 : kept_cnt_r;
  assign copy_now   = (phase_r == PH_COPY) || ((phase_r == PH_SKIP) && c_alnum);
  assign verdict_ok = vsf_r && (label_cnt_r != '0) && !hyph_r &&
                      !(kept_cnt_r > {1'b0, max_name_r});

  // Per-word scan step
  always_comb begin
    phase_nxt     = phase_r;
    label_cnt_nxt = label_cnt_r;
    kept_cnt_nxt  = kept_cnt_r;
    hyph_nxt      = hyph_r;
    vsf_nxt       = vsf_r;
    res_vld       = 1'b0;
    res           = '0;
    if (in_tlast) begin
      res_vld          = 1'b1;
      res.kind         = hlv_pkg::KindVerdict;
      res.host_valid   = verdict_ok;
      res.name_length  = kept_cnt_r;
      phase_nxt        = PH_SKIP;
      label_cnt_nxt    = '0;
      kept_cnt_nxt     = '0;
      hyph_nxt         = 1'b0;
      vsf_nxt          = 1'b1;
    end else if (copy_now) begin
      phase_nxt = PH_COPY;
      res.kind  = hlv_pkg::KindChar;
      if (c_space) begin
        phase_nxt = PH_STOP;
      end else if (c_lower || c_digit || c_upper) begin
        res_vld       = 1'b1;
        label_cnt_nxt = label_inc;
        if (label_over) vsf_nxt = 1'b0;
        hyph_nxt      = 1'b0;
        res.out_char  = c_upper ? c[hlv_pkg::CharW-1:0] + hlv_pkg::CaseShift
                                : c[hlv_pkg::CharW-1:0];
      end else if (c == hlv_pkg::ChPeriod) begin
        res_vld       = 1'b1;
        if ((label_cnt_r == '0) || hyph_r) vsf_nxt = 1'b0;
        label_cnt_nxt = '0;
        hyph_nxt      = 1'b0;
        res.out_char  = c[hlv_pkg::CharW-1:0];
      end else if (c == hlv_pkg::ChHyphen) begin
        res_vld       = 1'b1;
        if ((label_cnt_r == '0) || label_over) vsf_nxt = 1'b0;
        label_cnt_nxt = label_inc;
        hyph_nxt      = 1'b1;
        res.out_char  = c[hlv_pkg::CharW-1:0];
      end
      if (res_vld) kept_cnt_nxt = kept_inc;
    end
  end

  // Scan state, limit registers, output register and skid register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SKIP;
      label_cnt_r  <= '0;
      kept_cnt_r   <= '0;
      hyph_r       <= 1'b0;
      vsf_r        <= 1'b1;
      max_lbl_r    <= hlv_pkg::MaxLblReset;
      max_name_r   <= hlv_pkg::MaxNameReset;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_r     <= phase_nxt;
        label_cnt_r <= label_cnt_nxt;
        kept_cnt_r  <= kept_cnt_nxt;
        hyph_r      <= hyph_nxt;
        vsf_r       <= vsf_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          hlv_pkg::RegMaxLabel: max_lbl_r  <= cfg_wdata[hlv_pkg::MaxLblW-1:0];
          hlv_pkg::RegMaxName:  max_name_r <= cfg_wdata[hlv_pkg::MaxNameW-1:0];
          default: ;
        endcase
      end
      // Output word moves on, or a new word parks in the skid register
      if (out_valid_r && out_tready) begin
        if (skid_valid_r) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= in_acc && res_vld;
          out_r       <= res;
        end
      end else if (out_valid_r) begin
        if (in_acc && res_vld) begin
          skid_valid_r <= 1'b1;
          skid_r       <= res;
        end
      end else begin
        out_valid_r <= in_acc && res_vld;
        out_r       <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {{(hlv_pkg::OutDataW - hlv_pkg::CharW - 1 - hlv_pkg::KeptW){1'b0}},
                       out_r.name_length, out_r.host_valid, out_r.out_char};

  // Checks
  `CHK_IMPLY(a_skid_behind_out, skid_valid_r, out_valid_r)
  `CHK_IMPLY(a_verdict_no_char, out_valid_r && out_tuser, out_tdata[6:0] == 7'd0)
  `CHK_IMPLY(a_char_no_verdict, out_valid_r && !out_tuser, out_tdata[16:7] == 10'd0)
  `CHK_IMPLY(a_skip_nothing_kept, phase_r == PH_SKIP, kept_cnt_r == '0 && label_cnt_r == '0)
  `CHK_NEXT(a_end_clears, in_acc && in_tlast, phase_r == PH_SKIP && kept_cnt_r == '0 && vsf_r)

endmodule

[tb/sv/hlv_result_checker.sv]
// Result checker for the host name label validator: predicts and compares.
`timescale 1ns / 1ps

module hlv_result_checker
  import hlv_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_tready,
  input  logic [CodeW-1:0]    in_tdata,
  input  logic                in_tlast,
  input  logic                out_tvalid,
  input  logic                out_tready,
  input  logic [OutDataW-1:0] out_tdata,
  input  logic                out_tuser,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  output int                  fail_count,
  output int                  pending
);

  typedef enum logic [1:0] {
    ScanSkip = 2'd0,
    ScanCopy = 2'd1,
    ScanStop = 2'd2
  } scan_phase_e;

  // Predicted scan state and limits
  scan_phase_e         scan_phase;
  logic [LabelW-1:0]   label_len;
  logic [KeptW-1:0]    kept_len;
  logic                hyphen_last;
  logic                name_ok;
  logic [MaxLblW-1:0]  lbl_limit;
  logic [MaxNameW-1:0] name_limit;

  // Expected result words, oldest first
  result_t host_results_q[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic is_space(input logic [CodeW-1:0] c);
    return (c >= 16'h0009 && c <= 16'h000D) || (c >= 16'h2000 && c <= 16'h200A) ||
           c == 16'h0020 || c == 16'h0085 || c == 16'h00A0 || c == 16'h1680 ||
           c == 16'h2028 || c == 16'h2029 || c == 16'h202F || c == 16'h205F ||
           c == 16'h3000;
  endfunction

  task automatic clear_scan();
    scan_phase  = ScanSkip;
    label_len   = '0;
    kept_len    = '0;
    hyphen_last = 1'b0;
    name_ok     = 1'b1;
  endtask

  // Label grows by one up to saturation; over the limit spoils the name
  task automatic bump_label();
    if (label_len < LabelSat) label_len++;
    if (label_len > {1'b0, lbl_limit}) name_ok = 1'b0;
  endtask

  // One accepted code unit: update scan state, queue the word it causes
  task automatic scan_code_unit(input logic [CodeW-1:0] c, input logic eos);
    result_t r;
    logic    lower, upper, numeral, keep;
    r       = '0;
    keep    = 1'b0;
    lower   = c >= 16'h0061 && c <= 16'h007A;
    upper   = c >= 16'h0041 && c <= 16'h005A;
    numeral = c >= 16'h0030 && c <= 16'h0039;
    if (eos) begin
      r.kind        = KindVerdict;
      r.host_valid  = name_ok && label_len != 0 && !hyphen_last &&
                      kept_len <= {1'b0, name_limit};
      r.name_length = kept_len;
      host_results_q.push_back(r);
      clear_scan();
    end else begin
      if (scan_phase == ScanSkip && (lower || upper || numeral)) scan_phase = ScanCopy;
      if (scan_phase == ScanCopy) begin
        if (is_space(c)) begin
          scan_phase = ScanStop;
        end else if (lower || numeral) begin
          bump_label();
          r.out_char  = c[CharW-1:0];
          hyphen_last = 1'b0;
          keep        = 1'b1;
        end else if (upper) begin
          bump_label();
          r.out_char  = c[CharW-1:0] + CaseShift;
          hyphen_last = 1'b0;
          keep        = 1'b1;
        end else if (c == ChPeriod) begin
          // empty label or hyphen before the period
          if (label_len == 0 || hyphen_last) name_ok = 1'b0;
          label_len   = '0;
          r.out_char  = c[CharW-1:0];
          hyphen_last = 1'b0;
          keep        = 1'b1;
        end else if (c == ChHyphen) begin
          // hyphen opening a label
          if (label_len == 0) name_ok = 1'b0;
          bump_label();
          r.out_char  = c[CharW-1:0];
          hyphen_last = 1'b1;
          keep        = 1'b1;
        end
      end
      if (keep) begin
        if (kept_len < KeptSat) kept_len++;
        r.kind = KindChar;
        host_results_q.push_back(r);
      end
    end
  endtask

  task automatic check_field(input string fname, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      fail_count++;
    end
  endtask

  // Sample both channels and the config port at each rising edge
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      host_results_q.delete();
      clear_scan();
      lbl_limit  = MaxLblReset;
      name_limit = MaxNameReset;
    end else begin
      if (out_tvalid && out_tready) begin
        if (host_results_q.size() == 0) begin
          $error("result word with nothing expected: tuser %0d tdata %h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          want = host_results_q.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("out_char", want.out_char, out_tdata[6:0]);
          check_field("host_valid", want.host_valid, out_tdata[7]);
          check_field("name_length", want.name_length, out_tdata[16:8]);
          check_field("zero fill", 0, out_tdata[OutDataW-1:17]);
        end
      end
      if (in_tvalid && in_tready) scan_code_unit(in_tdata, in_tlast);
      if (cfg_we) begin
        if (cfg_index == RegMaxLabel) lbl_limit = cfg_wdata[MaxLblW-1:0];
        else name_limit = cfg_wdata[MaxNameW-1:0];
      end
    end
    pending = host_results_q.size();
  end

endmodule

[tb/sv/tb.sv]
// Testbench top for the host name label validator: stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import hlv_pkg::*;

  localparam int ItemTarget = 1600;
  localparam int NumPhases  = 7;
  localparam int HoldCycles = 240;
  localparam int StallLimit = 4000;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [CodeW-1:0]    in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  int   fail_count;
  int   pending_results;
  int   words_sent;
  int   cur_lbl;
  int   quiet_cycles;
  logic steady;
  logic rx_hold;

  always #2 clk = ~clk;

  hostname_label_validator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  hlv_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending_results)
  );

  // Receiver: random back-pressure, or one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        out_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        rx_hold = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [CodeW-1:0] alnum_code();
    int r;
    r = $urandom_range(0, 61);
    if (r < 26) return 16'h0061 + 16'(r);
    else if (r < 52) return 16'h0041 + 16'(r - 26);
    else return 16'h0030 + 16'(r - 52);
  endfunction

  function automatic logic [CodeW-1:0] space_code();
    case ($urandom_range(0, 10))
      0:       return 16'h0009 + 16'($urandom_range(0, 4));
      1:       return 16'h0020;
      2:       return 16'h0085;
      3:       return 16'h00A0;
      4:       return 16'h1680;
      5:       return 16'h2000 + 16'($urandom_range(0, 10));
      6:       return 16'h2028;
      7:       return 16'h2029;
      8:       return 16'h202F;
      9:       return 16'h205F;
      default: return 16'h3000;
    endcase
  endfunction

  // Units that break or dirty a name
  function automatic logic [CodeW-1:0] odd_code();
    case ($urandom_range(0, 4))
      0:       return ChHyphen;
      1:       return 16'($urandom_range(0, 65535));
      2:       return 16'h0021 + 16'($urandom_range(0, 14));
      3:       return space_code();
      default: return ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
    endcase
  endfunction

  // Offer one word and hold it until accepted
  task automatic send_word(input logic [CodeW-1:0] code, input logic last);
    if (!steady && $urandom_range(0, 99) < 14) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= code;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word({8'h00, s[i]}, 1'b0);
  endtask

  // End of text; its code is noise
  task automatic end_name();
    send_word(16'($urandom_range(0, 65535)), 1'b1);
  endtask

  task automatic send_label(input int len);
    int r;
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (i > 0 && i < len - 1 && r < 12) send_word(ChHyphen, 1'b0);
      else if (r >= 94) send_word(odd_code(), 1'b0);
      else send_word(alnum_code(), 1'b0);
    end
  endtask

  // Mostly well-formed names with random content, some noise and broken ones
  task automatic send_host_name();
    int style, n_labels, len;
    style = $urandom_range(0, 99);
    if (style < 8) begin
      repeat ($urandom_range(0, 10)) send_word(16'($urandom_range(0, 65535)), 1'b0);
    end else begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) send_word(odd_code(), 1'b0);
      end
      n_labels = $urandom_range(1, 4);
      for (int l = 0; l < n_labels; l++) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, cur_lbl + 2) : $urandom_range(1, 6);
        send_label(len);
        if (l < n_labels - 1) send_word(ChPeriod, 1'b0);
      end
      style = $urandom_range(0, 99);
      if (style < 6) begin
        send_word(ChPeriod, 1'b0);
      end else if (style < 12) begin
        send_word(space_code(), 1'b0);
        repeat ($urandom_range(0, 3)) send_word(alnum_code(), 1'b0);
      end
    end
    end_name();
  endtask

  // Stop offering, let every expected word drain, then cover the latency
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_limits(input logic [CfgDataW-1:0] lbl, input logic [CfgDataW-1:0] name);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= RegMaxLabel;
    cfg_wdata <= lbl;
    @(negedge clk);
    cfg_index <= RegMaxName;
    cfg_wdata <= name;
    @(negedge clk);
    cfg_we    <= 1'b0;
    cur_lbl = lbl & 8'h3F;
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    steady     = 1'b0;
    rx_hold    = 1'b0;
    words_sent = 0;
    cur_lbl    = 63;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: skipped zero and hyphen, case fold, dropped unit, hyphen before period
    send_word(16'h0000, 1'b0);
    send_text("-Za0");
    send_word(16'hFFFF, 1'b0);
    send_text("-.9");
    end_name();
    // empty label, hyphen opening a label, trailing hyphen
    send_text("a..-");
    end_name();
    // whitespace stops copying, later units ignored
    send_text("z");
    send_word(16'h3000, 1'b0);
    send_text("q");
    end_name();
    // empty name
    end_name();
    // zero unit inside a name is dropped
    send_text("A");
    send_word(16'h0000, 1'b0);
    send_text("9");
    end_name();

    // Random phases over several limit settings
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: set_limits(8'd3, 8'd20);
        1: set_limits(8'd0, 8'd0);
        2: set_limits(8'd1, 8'd1);
        3: set_limits(8'hFF, 8'd1);
        4: set_limits(8'hC5, 8'd40);
        5: set_limits(8'd12, 8'd255);
        default: set_limits(8'd63, 8'd255);
      endcase
      steady = (p == 2);
      if (p == 3) begin
        // receiver holds off while a long run of letters and digits is offered
        rx_hold = 1'b1;
        repeat (40) send_word(alnum_code(), 1'b0);
        end_name();
      end
      if (p == NumPhases - 1) begin
        // over-long labels and name: both counters saturate
        for (int l = 0; l < 4; l++) begin
          repeat (130) send_word(alnum_code(), 1'b0);
          if (l < 3) send_word(ChPeriod, 1'b0);
        end
        end_name();
      end
      while (words_sent < 24 + (p + 1) * (ItemTarget / NumPhases)) send_host_name();
    end
    steady = 1'b0;

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
